### rtl/egcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Widths shared by the extended greatest common divisor unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int COEFF_WIDTH   = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int S_DATA_WIDTH  = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH  = ((OPERAND_WIDTH + 2 * COEFF_WIDTH + 7) / 8) * 8;

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [COEFF_WIDTH-1:0]   coeff_t;

endpackage

### rtl/extended_gcd_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Greatest common divisor with Bezout coefficients, built around one shared
// restoring divide step that also accumulates the quotient times each
// coefficient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: the input beat is taken in ST_IDLE; each Euclid step passes through ST_CHECK,
// ST_DIV and ST_UPD, until ST_CHECK finds a zero remainder and ST_FIN loads the output
// register and raises m_tvalid. Throughput: one beat at a time; the next input beat is
// taken once the current result has moved into the output register.
// The divide loop runs one quotient bit per cycle through a single subtractor.
// Reset clears the sequencer and the output valid flag; no other register is reset.
module extended_gcd_unit
    import egcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // first_operand, second_operand
    input  logic [S_DATA_WIDTH-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // divisor, coeff_first, coeff_second, zero fill
    output logic [M_DATA_WIDTH-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);
    localparam int PAD_WIDTH = M_DATA_WIDTH - OPERAND_WIDTH - 2 * COEFF_WIDTH;

    logic [2:0]           state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    operand_t             rp_reg, rc_reg, part_reg, dvd_reg;
    coeff_t               xp_reg, xc_reg, yp_reg, yc_reg, tx_reg, ty_reg;
    logic                 out_valid_reg;
    operand_t             out_div_reg;
    coeff_t               out_x_reg, out_y_reg;

    logic [OPERAND_WIDTH:0] trial;
    logic [OPERAND_WIDTH:0] diff;
    logic                   ge;
    operand_t               part_next;
    logic                   load_out;

    assign trial     = {part_reg, dvd_reg[OPERAND_WIDTH-1]};
    assign diff      = trial - {1'b0, rc_reg};
    assign ge        = trial >= {1'b0, rc_reg};
    assign part_next = ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_WIDTH{1'b0}}, out_y_reg, out_x_reg, out_div_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (rc_reg == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_CHECK;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rp_reg <= s_tdata[OPERAND_WIDTH-1:0];
                rc_reg <= s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
                xp_reg <= COEFF_WIDTH'(1);
                xc_reg <= '0;
                yp_reg <= '0;
                yc_reg <= COEFF_WIDTH'(1);
            end
            ST_CHECK:
            begin
                part_reg <= '0;
                dvd_reg  <= rp_reg;
                tx_reg   <= '0;
                ty_reg   <= '0;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                part_reg <= part_next;
                dvd_reg  <= {dvd_reg[OPERAND_WIDTH-2:0], 1'b0};
                tx_reg   <= {tx_reg[COEFF_WIDTH-2:0], 1'b0} + (ge ? xc_reg : '0);
                ty_reg   <= {ty_reg[COEFF_WIDTH-2:0], 1'b0} + (ge ? yc_reg : '0);
                cnt_reg  <= cnt_reg + CNT_WIDTH'(1);
            end
            ST_UPD:
            begin
                rp_reg <= rc_reg;
                rc_reg <= part_reg;
                xp_reg <= xc_reg;
                xc_reg <= xp_reg - tx_reg;
                yp_reg <= yc_reg;
                yc_reg <= yp_reg - ty_reg;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    out_div_reg <= rp_reg;
                    out_x_reg   <= xp_reg;
                    out_y_reg   <= yp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rc_reg != '0))
        else $error("Divide loop running with a zero divisor.");

    a_part_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (part_reg < rc_reg))
        else $error("Partial remainder is not below the divisor.");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_tready && (state_reg != ST_FIN)) |=> !out_valid_reg)
        else $error("Output beat taken but valid stayed high.");
`endif

endmodule
